// File: rtl/waypoint_heading_rate_controller_assert.svh
// Assertion macros shared by the waypoint heading-rate controller RTL.
`ifndef WAYPOINT_HEADING_RATE_CONTROLLER_ASSERT_SVH
`define WAYPOINT_HEADING_RATE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WPHRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wphrc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WPHRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wphrc: next-cycle check failed");

`endif

// File: rtl/wphrc_pkg.sv
// Types, constants and the arctangent table of the waypoint heading-rate controller.
package wphrc_pkg;

    // Widths fixed by the item and register formats.
    localparam int POS_IN_W  = 32;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int OFFSET_W  = 24;
    localparam int HOLD_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int TIME_W    = 32;
    localparam int ZACC_W    = 32;
    localparam int ATAN_IDX_W = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_NORTH = 3'd0,
        REG_OFFSET_EAST  = 3'd1,
        REG_HOLD_OFF     = 3'd2,
        REG_YAW_GAIN     = 3'd3,
        REG_RATE_LIMIT   = 3'd4
    } cfg_reg_t;

    // Register reset values.
    localparam logic [HOLD_W-1:0]  HOLD_OFF_RESET   = 16'd500;
    localparam logic [GAIN_W-1:0]  YAW_GAIN_RESET   = 16'd12868;
    localparam logic [LIMIT_W-1:0] RATE_LIMIT_RESET = 15'd2048;

    // Pre-rotation angles, a quarter and three quarters of a turn; rounding half.
    localparam logic [ZACC_W-1:0] Z_QUARTER       = 32'h4000_0000;
    localparam logic [ZACC_W-1:0] Z_THREE_QUARTER = 32'hC000_0000;
    localparam logic [ZACC_W-1:0] Z_ROUND_HALF    = 32'h0000_8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREROT,
        ST_ITER,
        ST_ROUND,
        ST_MUL,
        ST_OUTPUT
    } state_t;

    // atan(2^-i) with a full turn as 2^32.
    function automatic logic [ZACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZACC_W-1:0] val;
        unique case (idx)
            5'd0:  val = 32'h2000_0000;
            5'd1:  val = 32'h12E4_051E;
            5'd2:  val = 32'h09FB_385B;
            5'd3:  val = 32'h0511_11D4;
            5'd4:  val = 32'h028B_0D43;
            5'd5:  val = 32'h0145_D7E1;
            5'd6:  val = 32'h00A2_F61E;
            5'd7:  val = 32'h0051_7C55;
            5'd8:  val = 32'h0028_BE53;
            5'd9:  val = 32'h0014_5F2F;
            5'd10: val = 32'h000A_2F98;
            5'd11: val = 32'h0005_17CC;
            5'd12: val = 32'h0002_8BE6;
            5'd13: val = 32'h0001_45F3;
            5'd14: val = 32'h0000_A2FA;
            5'd15: val = 32'h0000_517D;
            5'd16: val = 32'h0000_28BE;
            5'd17: val = 32'h0000_145F;
            5'd18: val = 32'h0000_0A30;
            5'd19: val = 32'h0000_0518;
            5'd20: val = 32'h0000_028C;
            5'd21: val = 32'h0000_0146;
            5'd22: val = 32'h0000_00A3;
            5'd23: val = 32'h0000_0051;
            5'd24: val = 32'h0000_0029;
            5'd25: val = 32'h0000_0014;
            5'd26: val = 32'h0000_000A;
            5'd27: val = 32'h0000_0005;
            5'd28: val = 32'h0000_0003;
            5'd29: val = 32'h0000_0001;
            5'd30: val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/waypoint_heading_rate_controller.sv
// Waypoint heading-rate controller: target capture, sample hold-off, CORDIC bearing and rate command.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | kind, time_ms, pos_valid, pos_north, pos_east, yaw_now
//  out     | out_valid / out_stall | rate_cmd, bearing, heading_error
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An enter item or a dropped sample passes through the decode state only. A sample that yields a
// result runs through the pre-rotation, rotation, rounding, multiply and output states, using
// the single CORDIC iteration unit that handles one rotation per cycle; a position on the target
// skips the rotations. The next item can be accepted once the output register is loaded. A result
// waits in the output register while out_stall is high; the next item is then still accepted, but
// its result is held back until the register is free. Reset is asynchronous and restores every
// configuration register and clears the controller state.
module waypoint_heading_rate_controller #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_WIDTH    = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wphrc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wphrc_pkg::CFG_DAT_W-1:0]        cfg_data,
    // input items
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic [wphrc_pkg::TIME_W-1:0]           time_ms,
    input  logic                                   pos_valid,
    input  logic signed [wphrc_pkg::POS_IN_W-1:0]  pos_north,
    input  logic signed [wphrc_pkg::POS_IN_W-1:0]  pos_east,
    input  logic signed [wphrc_pkg::ANGLE_W-1:0]   yaw_now,
    // result items
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [wphrc_pkg::ANGLE_W-1:0]   rate_cmd,
    output logic signed [wphrc_pkg::ANGLE_W-1:0]   bearing,
    output logic signed [wphrc_pkg::ANGLE_W-1:0]   heading_error
);
    import wphrc_pkg::*;

    `include "waypoint_heading_rate_controller_assert.svh"

    localparam int WW = (POS_WIDTH > POS_IN_W) ? POS_WIDTH : POS_IN_W;
    localparam int DW = WW + 1;   // position sums and differences
    localparam int CW = DW + 2;   // CORDIC vector, room for the gain of about 1.65
    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PW = 2 * ANGLE_W + 2;   // product of the negated error and the gain
    localparam int CMD_W = PW - ANGLE_W;

    // Configuration registers.
    logic signed [OFFSET_W-1:0] offset_north_reg;
    logic signed [OFFSET_W-1:0] offset_east_reg;
    logic [HOLD_W-1:0]          hold_off_reg;
    logic [GAIN_W-1:0]          yaw_gain_reg;
    logic [LIMIT_W-1:0]         rate_limit_reg;

    // Controller state.
    state_t                      state_reg, state_next;
    logic [TIME_W-1:0]           last_sample_reg;
    logic                        start_valid_reg;
    logic signed [POS_WIDTH-1:0] target_north_reg;
    logic signed [POS_WIDTH-1:0] target_east_reg;
    logic [IW-1:0]               step_reg;

    // Captured item.
    logic                        kind_reg;
    logic [TIME_W-1:0]           time_reg;
    logic                        pos_valid_reg;
    logic signed [POS_IN_W-1:0]  pos_north_reg;
    logic signed [POS_IN_W-1:0]  pos_east_reg;
    logic signed [ANGLE_W-1:0]   yaw_reg;

    // Datapath.
    logic signed [CW-1:0]        x_reg;
    logic signed [CW-1:0]        y_reg;
    logic [ZACC_W-1:0]           z_reg;
    logic signed [ANGLE_W-1:0]   bearing_reg;
    logic signed [ANGLE_W-1:0]   err_reg;
    logic signed [PW-1:0]        prod_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [ANGLE_W-1:0]   cmd_out_reg;
    logic signed [ANGLE_W-1:0]   bearing_out_reg;
    logic signed [ANGLE_W-1:0]   err_out_reg;

    logic in_accept;
    logic out_load;
    logic held_off;
    logic do_sample;
    logic zero_vec;
    logic last_step;

    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != ST_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign rate_cmd      = cmd_out_reg;
    assign bearing       = bearing_out_reg;
    assign heading_error = err_out_reg;

    // ---------------------------------------------------------------- decode arithmetic
    logic [TIME_W-1:0]    elapsed;
    logic signed [DW-1:0] sum_north, sum_east;
    logic signed [POS_WIDTH-1:0] sat_north, sat_east;
    logic signed [DW-1:0] delta_north, delta_east;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [DW-1:0] v);
        logic [DW-POS_WIDTH:0] upper;
        logic signed [POS_WIDTH-1:0] res;
        upper = v[DW-1:POS_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            res = v[POS_WIDTH-1:0];
        end
        else if (v[DW-1])
        begin
            res = {1'b1, {(POS_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(POS_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb
    begin
        elapsed     = time_reg - last_sample_reg;
        held_off    = elapsed < TIME_W'(hold_off_reg);
        do_sample   = start_valid_reg && pos_valid_reg;
        sum_north   = DW'(pos_north_reg) + DW'(offset_north_reg);
        sum_east    = DW'(pos_east_reg) + DW'(offset_east_reg);
        sat_north   = sat_pos(sum_north);
        sat_east    = sat_pos(sum_east);
        delta_north = DW'(target_north_reg) - DW'(pos_north_reg);
        delta_east  = DW'(target_east_reg) - DW'(pos_east_reg);
    end

    // ---------------------------------------------------------------- shared CORDIC step
    logic signed [CW-1:0] x_shift, y_shift;
    logic [ZACC_W-1:0]    atan_val;
    logic                 rot_neg;

    always_comb
    begin
        x_shift   = x_reg >>> step_reg;
        y_shift   = y_reg >>> step_reg;
        atan_val  = atan_entry(ATAN_IDX_W'(step_reg));
        rot_neg   = (y_reg > 0);
        zero_vec  = (x_reg == '0) && (y_reg == '0);
        last_step = (step_reg == IW'(CORDIC_STEPS - 1));
    end

    // ---------------------------------------------------------------- rate arithmetic
    logic [ZACC_W-1:0]         z_rounded;
    logic signed [ANGLE_W-1:0] bearing_calc;
    logic signed [ANGLE_W:0]   neg_err;
    logic signed [ANGLE_W:0]   gain_s;
    logic signed [PW-1:0]      prod_calc;
    logic signed [PW-1:0]      prod_rnd;
    logic signed [CMD_W-1:0]   cmd_raw, lim_pos, lim_neg, cmd_clamped;

    always_comb
    begin
        z_rounded    = z_reg + Z_ROUND_HALF;
        bearing_calc = z_rounded[ZACC_W-1:ZACC_W-ANGLE_W];
        neg_err      = -((ANGLE_W+1)'(err_reg));
        gain_s       = {1'b0, yaw_gain_reg};
        prod_calc    = PW'(neg_err) * PW'(gain_s);
        prod_rnd     = prod_reg + PW'(34'sd32768);
        cmd_raw      = prod_rnd[PW-1:ANGLE_W];
        lim_pos      = CMD_W'({1'b0, rate_limit_reg});
        lim_neg      = -lim_pos;
        if (cmd_raw > lim_pos)
        begin
            cmd_clamped = lim_pos;
        end
        else if (cmd_raw < lim_neg)
        begin
            cmd_clamped = lim_neg;
        end
        else
        begin
            cmd_clamped = cmd_raw;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (kind_reg && !held_off && do_sample)
                begin
                    state_next = ST_PREROT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREROT:
            begin
                // A vector of zero length keeps a zero angle and skips the rotations.
                state_next = zero_vec ? ST_ROUND : ST_ITER;
            end
            ST_ITER:
            begin
                if (last_step)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_north_reg <= '0;
            offset_east_reg  <= '0;
            hold_off_reg     <= HOLD_OFF_RESET;
            yaw_gain_reg     <= YAW_GAIN_RESET;
            rate_limit_reg   <= RATE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OFFSET_NORTH: offset_north_reg <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_EAST:  offset_east_reg  <= cfg_data[OFFSET_W-1:0];
                REG_HOLD_OFF:     hold_off_reg     <= cfg_data[HOLD_W-1:0];
                REG_YAW_GAIN:     yaw_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_RATE_LIMIT:   rate_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------- controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= '0;
            start_valid_reg  <= 1'b0;
            target_north_reg <= '0;
            target_east_reg  <= '0;
        end
        else if (state_reg == ST_DECODE)
        begin
            if (!kind_reg)
            begin
                start_valid_reg <= pos_valid_reg;
                if (pos_valid_reg)
                begin
                    target_north_reg <= sat_north;
                    target_east_reg  <= sat_east;
                end
            end
            else if (!held_off)
            begin
                last_sample_reg <= time_reg;
            end
        end
    end

    // ---------------------------------------------------------------- item capture and datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg      <= kind;
            time_reg      <= time_ms;
            pos_valid_reg <= pos_valid;
            pos_north_reg <= pos_north;
            pos_east_reg  <= pos_east;
            yaw_reg       <= yaw_now;
        end

        case (state_reg)
            ST_DECODE:
            begin
                x_reg <= CW'(delta_north);
                y_reg <= CW'(delta_east);
                z_reg <= '0;
            end
            ST_PREROT:
            begin
                step_reg <= '0;
                // Move a vector in the left half plane into the right half plane.
                if (x_reg < 0)
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                        z_reg <= Z_QUARTER;
                    end
                    else
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                        z_reg <= Z_THREE_QUARTER;
                    end
                end
            end
            ST_ITER:
            begin
                step_reg <= step_reg + 1'b1;
                if (rot_neg)
                begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    z_reg <= z_reg + atan_val;
                end
                else
                begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    z_reg <= z_reg - atan_val;
                end
            end
            ST_ROUND:
            begin
                bearing_reg <= bearing_calc;
                err_reg     <= bearing_calc - yaw_reg;
            end
            ST_MUL:
            begin
                prod_reg <= prod_calc;
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            cmd_out_reg     <= cmd_clamped[ANGLE_W-1:0];
            bearing_out_reg <= bearing_reg;
            err_out_reg     <= err_reg;
        end
    end

    // ---------------------------------------------------------------- output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- assertions
    `WPHRC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `WPHRC_ASSERT_IMP(a_result_from_output, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_OUTPUT)
    `WPHRC_ASSERT_IMP(a_iter_x_nonneg, clk, rst_n, state_reg == ST_ITER, !x_reg[CW-1])

endmodule
